/* hdl/sha512_pkg.sv */
// ----------------------------------------------------------------------------
// sha512_pkg
// Shared types, round constants and helper functions for the SHA-512 engine.
// ----------------------------------------------------------------------------
package sha512_pkg;

	typedef enum logic [1:0] {
		CMD_ABSORB  = 2'd0,
		CMD_FINAL   = 2'd1,
		CMD_READ    = 2'd2,
		CMD_RESTART = 2'd3
	} cmd_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_PAD,
		S_LEN,
		S_ROUND,
		S_ADD,
		S_EMIT
	} state_t;

	// where to resume once a compression finishes
	typedef enum logic [1:0] {
		RET_IDLE,
		RET_PAD,
		RET_FINAL
	} ret_t;

	// one classified command as it travels from front to back
	typedef struct packed {
		cmd_t       op;
		logic [7:0] byte_val;
		logic [2:0] nbits;
	} item_t;

	localparam logic [6:0] LEN_START  = 7'd112;
	localparam logic [6:0] BLOCK_LAST = 7'd127;
	localparam logic [6:0] ROUND_LAST = 7'd79;

	localparam logic [63:0] IV [8] = '{
		64'h6a09e667f3bcc908, 64'hbb67ae8584caa73b, 64'h3c6ef372fe94f82b,
		64'ha54ff53a5f1d36f1, 64'h510e527fade682d1, 64'h9b05688c2b3e6c1f,
		64'h1f83d9abfb41bd6b, 64'h5be0cd19137e2179
	};

	localparam logic [63:0] ROUND_K [80] = '{
		64'h428A2F98D728AE22, 64'h7137449123EF65CD, 64'hB5C0FBCFEC4D3B2F, 64'hE9B5DBA58189DBBC,
		64'h3956C25BF348B538, 64'h59F111F1B605D019, 64'h923F82A4AF194F9B, 64'hAB1C5ED5DA6D8118,
		64'hD807AA98A3030242, 64'h12835B0145706FBE, 64'h243185BE4EE4B28C, 64'h550C7DC3D5FFB4E2,
		64'h72BE5D74F27B896F, 64'h80DEB1FE3B1696B1, 64'h9BDC06A725C71235, 64'hC19BF174CF692694,
		64'hE49B69C19EF14AD2, 64'hEFBE4786384F25E3, 64'h0FC19DC68B8CD5B5, 64'h240CA1CC77AC9C65,
		64'h2DE92C6F592B0275, 64'h4A7484AA6EA6E483, 64'h5CB0A9DCBD41FBD4, 64'h76F988DA831153B5,
		64'h983E5152EE66DFAB, 64'hA831C66D2DB43210, 64'hB00327C898FB213F, 64'hBF597FC7BEEF0EE4,
		64'hC6E00BF33DA88FC2, 64'hD5A79147930AA725, 64'h06CA6351E003826F, 64'h142929670A0E6E70,
		64'h27B70A8546D22FFC, 64'h2E1B21385C26C926, 64'h4D2C6DFC5AC42AED, 64'h53380D139D95B3DF,
		64'h650A73548BAF63DE, 64'h766A0ABB3C77B2A8, 64'h81C2C92E47EDAEE6, 64'h92722C851482353B,
		64'hA2BFE8A14CF10364, 64'hA81A664BBC423001, 64'hC24B8B70D0F89791, 64'hC76C51A30654BE30,
		64'hD192E819D6EF5218, 64'hD69906245565A910, 64'hF40E35855771202A, 64'h106AA07032BBD1B8,
		64'h19A4C116B8D2D0C8, 64'h1E376C085141AB53, 64'h2748774CDF8EEB99, 64'h34B0BCB5E19B48A8,
		64'h391C0CB3C5C95A63, 64'h4ED8AA4AE3418ACB, 64'h5B9CCA4F7763E373, 64'h682E6FF3D6B2B8A3,
		64'h748F82EE5DEFB2FC, 64'h78A5636F43172F60, 64'h84C87814A1F0AB72, 64'h8CC702081A6439EC,
		64'h90BEFFFA23631E28, 64'hA4506CEBDE82BDE9, 64'hBEF9A3F7B2C67915, 64'hC67178F2E372532B,
		64'hCA273ECEEA26619C, 64'hD186B8C721C0C207, 64'hEADA7DD6CDE0EB1E, 64'hF57D4F7FEE6ED178,
		64'h06F067AA72176FBA, 64'h0A637DC5A2C898A6, 64'h113F9804BEF90DAE, 64'h1B710B35131C471B,
		64'h28DB77F523047D84, 64'h32CAAB7B40C72493, 64'h3C9EBE0A15C9BEBC, 64'h431D67C49C100D4C,
		64'h4CC5D4BECB3E42B6, 64'h597F299CFC657E2A, 64'h5FCB6FAB3AD6FAEC, 64'h6C44198C4A475817
	};

	function automatic logic [63:0] big_sigma0(input logic [63:0] x);
		big_sigma0 = {x[27:0], x[63:28]} ^ {x[33:0], x[63:34]} ^ {x[38:0], x[63:39]};
	endfunction

	function automatic logic [63:0] big_sigma1(input logic [63:0] x);
		big_sigma1 = {x[13:0], x[63:14]} ^ {x[17:0], x[63:18]} ^ {x[40:0], x[63:41]};
	endfunction

	function automatic logic [63:0] small_sigma0(input logic [63:0] x);
		small_sigma0 = {x[0], x[63:1]} ^ {x[7:0], x[63:8]} ^ (x >> 7);
	endfunction

	function automatic logic [63:0] small_sigma1(input logic [63:0] x);
		small_sigma1 = {x[18:0], x[63:19]} ^ {x[60:0], x[63:61]} ^ (x >> 6);
	endfunction

endpackage

/* hdl/sha512_front.sv */
// ----------------------------------------------------------------------------
// sha512_front
// Accepts commands and classifies them; a finalize gets its padded
// trailing byte (kept bits plus marker bit) built here.
// ----------------------------------------------------------------------------
module sha512_front import sha512_pkg::*; (
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [1:0] cmd,
	input  logic [7:0] data_byte,
	input  logic [2:0] partial_bits,
	output logic       push,
	output item_t      push_item,
	input  logic       queue_full
);

	logic [7:0] keep;
	logic [7:0] mark;

	// build the trailing byte of a finalize
	always_comb begin
		keep = ~(8'hFF >> partial_bits);
		mark = 8'h80 >> partial_bits;
		push_item.op = cmd_t'(cmd);
		push_item.nbits = partial_bits;
		if (cmd_t'(cmd) == CMD_FINAL) begin
			push_item.byte_val = (data_byte & keep) | mark;
		end else begin
			push_item.byte_val = data_byte;
		end
	end

	// transfer into the queue while it has room
	assign in_ready = !queue_full;
	assign push = in_valid && !queue_full;

endmodule

/* hdl/sha512_queue.sv */
// ----------------------------------------------------------------------------
// sha512_queue
// Two-entry command queue between the front and the back.
// ----------------------------------------------------------------------------
module sha512_queue import sha512_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  item_t push_item,
	output logic  full,
	input  logic  pop,
	output logic  head_valid,
	output item_t head_item
);

	item_t      mem_q [2];
	logic       wr_q;
	logic       rd_q;
	logic [1:0] count_q;

	assign full = count_q == 2'd2;
	assign head_valid = count_q != 2'd0;
	assign head_item = mem_q[rd_q];

	// advance pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= 1'b0;
			rd_q <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (push) wr_q <= ~wr_q;
			if (pop) rd_q <= ~rd_q;
			count_q <= count_q + {1'b0, push} - {1'b0, pop};
		end
	end

	// hold entries
	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= push_item;
	end

	assert property (@(posedge clk) disable iff (!arst_n) pop |-> head_valid)
		else $error("pop from empty queue");
	assert property (@(posedge clk) disable iff (!arst_n) push |-> !full)
		else $error("push into full queue");
	assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == 2'd0) |-> (wr_q == rd_q))
		else $error("queue pointers disagree with empty count");

endmodule

/* hdl/sha512_core.sv */
// ----------------------------------------------------------------------------
// sha512_core
// Back part: collects bytes into the 16-word schedule window, pads, runs
// one SHA-512 round per cycle and drives the result register.
// ----------------------------------------------------------------------------
module sha512_core import sha512_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        head_valid,
	input  item_t       head_item,
	output logic        pop,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        status,
	output logic [63:0] digest_word,
	output logic [2:0]  word_index,
	output logic        last
);

	state_t       state_q, state_d;
	ret_t         ret_q, ret_d;
	logic [6:0]   fill_q;
	logic [6:0]   rnd_q;
	logic [2:0]   idx_q;
	logic         done_q;
	logic [127:0] cnt_q;
	logic [63:0]  h_q [8];
	logic [63:0]  v_q [8];
	logic [63:0]  w_q [16];
	logic [63:0]  cur_q;
	logic         out_valid_q;
	logic         status_q;
	logic [63:0]  word_q;
	logic [2:0]   index_q;
	logic         last_q;

	logic         out_free;
	logic         can_go;
	logic         append_en;
	logic [7:0]   append_byte;
	logic [3:0]   cnt_inc;
	logic         push_single;
	logic         push_err;
	logic         push_word;
	logic         load_init;
	logic [7:0]   len_byte;
	logic [63:0]  cur_next;
	logic [63:0]  t1, t2, sched;

	assign out_free = !out_valid_q || out_ready;
	assign can_go = head_valid && out_free;
	assign len_byte = cnt_q[{4'd15 - fill_q[3:0], 3'b000} +: 8];
	assign cur_next = {cur_q[55:0], append_byte};

	// round datapath
	always_comb begin
		t1 = v_q[7] + big_sigma1(v_q[4]) + ((v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]))
			+ ROUND_K[rnd_q] + w_q[0];
		t2 = big_sigma0(v_q[0]) + ((v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]));
		sched = small_sigma1(w_q[14]) + w_q[9] + small_sigma0(w_q[1]) + w_q[0];
	end

	// next state
	always_comb begin
		state_d = state_q;
		ret_d = ret_q;
		case (state_q)
			S_IDLE: begin
				if (can_go) begin
					case (head_item.op)
						CMD_ABSORB: begin
							if (!done_q && fill_q == BLOCK_LAST) begin
								state_d = S_ROUND;
								ret_d = RET_IDLE;
							end
						end
						CMD_FINAL: begin
							if (!done_q) begin
								state_d = (fill_q == BLOCK_LAST) ? S_ROUND : S_PAD;
								ret_d = RET_PAD;
							end
						end
						CMD_READ: begin
							if (done_q) state_d = S_EMIT;
						end
						default: ;
					endcase
				end
			end
			S_PAD: begin
				if (fill_q == LEN_START) begin
					state_d = S_LEN;
				end else if (fill_q == BLOCK_LAST) begin
					state_d = S_ROUND;
					ret_d = RET_PAD;
				end
			end
			S_LEN: begin
				if (fill_q == BLOCK_LAST) begin
					state_d = S_ROUND;
					ret_d = RET_FINAL;
				end
			end
			S_ROUND: begin
				if (rnd_q == ROUND_LAST) state_d = S_ADD;
			end
			S_ADD: begin
				case (ret_q)
					RET_PAD:   state_d = S_PAD;
					RET_FINAL: state_d = S_EMIT;
					default:   state_d = S_IDLE;
				endcase
			end
			S_EMIT: begin
				if (out_free && idx_q == 3'd7) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	// control outputs
	always_comb begin
		pop = 1'b0;
		append_en = 1'b0;
		append_byte = 8'd0;
		cnt_inc = 4'd0;
		push_single = 1'b0;
		push_err = 1'b0;
		push_word = 1'b0;
		load_init = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (can_go) begin
					pop = 1'b1;
					case (head_item.op)
						CMD_ABSORB: begin
							push_single = 1'b1;
							push_err = done_q;
							append_en = !done_q;
							append_byte = head_item.byte_val;
							cnt_inc = done_q ? 4'd0 : 4'd8;
						end
						CMD_FINAL: begin
							push_single = done_q;
							push_err = done_q;
							append_en = !done_q;
							append_byte = head_item.byte_val;
							cnt_inc = done_q ? 4'd0 : {1'b0, head_item.nbits};
						end
						CMD_READ: begin
							push_single = !done_q;
							push_err = !done_q;
						end
						default: begin
							push_single = 1'b1;
							load_init = 1'b1;
						end
					endcase
				end
			end
			S_PAD: begin
				append_en = fill_q != LEN_START;
			end
			S_LEN: begin
				append_en = 1'b1;
				append_byte = len_byte;
			end
			S_EMIT: begin
				push_word = out_free;
			end
			default: ;
		endcase
	end

	// control and hash state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			ret_q <= RET_IDLE;
			fill_q <= 7'd0;
			rnd_q <= 7'd0;
			idx_q <= 3'd0;
			done_q <= 1'b0;
			cnt_q <= '0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < 8; i++) h_q[i] <= IV[i];
		end else begin
			state_q <= state_d;
			ret_q <= ret_d;
			if (append_en) fill_q <= fill_q + 7'd1;
			if (append_en && head_item.op == CMD_ABSORB && state_q == S_IDLE) begin
				cnt_q <= cnt_q + 128'd8;
			end else begin
				cnt_q <= cnt_q + {124'd0, cnt_inc};
			end
			if (state_q == S_ROUND) begin
				rnd_q <= (rnd_q == ROUND_LAST) ? 7'd0 : rnd_q + 7'd1;
			end
			idx_q <= (state_q == S_EMIT) ? idx_q + {2'd0, push_word} : 3'd0;
			if (state_q == S_ADD) begin
				for (int i = 0; i < 8; i++) h_q[i] <= h_q[i] + v_q[i];
				if (ret_q == RET_FINAL) begin
					done_q <= 1'b1;
					cnt_q <= '0;
				end
			end
			if (load_init) begin
				for (int i = 0; i < 8; i++) h_q[i] <= IV[i];
				fill_q <= 7'd0;
				cnt_q <= '0;
				done_q <= 1'b0;
			end
			if (push_single || push_word) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// schedule window, working variables and result payload
	always_ff @(posedge clk) begin
		if (append_en) begin
			cur_q <= cur_next;
			if (fill_q[2:0] == 3'd7) begin
				for (int i = 0; i < 15; i++) w_q[i] <= w_q[i + 1];
				w_q[15] <= cur_next;
			end
		end
		if (state_q == S_ROUND) begin
			for (int i = 0; i < 15; i++) w_q[i] <= w_q[i + 1];
			w_q[15] <= sched;
			v_q[7] <= v_q[6];
			v_q[6] <= v_q[5];
			v_q[5] <= v_q[4];
			v_q[4] <= v_q[3] + t1;
			v_q[3] <= v_q[2];
			v_q[2] <= v_q[1];
			v_q[1] <= v_q[0];
			v_q[0] <= t1 + t2;
		end else begin
			for (int i = 0; i < 8; i++) v_q[i] <= h_q[i];
		end
		if (push_single) begin
			status_q <= push_err;
			word_q <= 64'd0;
			index_q <= 3'd0;
			last_q <= 1'b1;
		end else if (push_word) begin
			status_q <= 1'b0;
			word_q <= h_q[idx_q];
			index_q <= idx_q;
			last_q <= idx_q == 3'd7;
		end
	end

	assign out_valid = out_valid_q;
	assign status = status_q;
	assign digest_word = word_q;
	assign word_index = index_q;
	assign last = last_q;

	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_ADD) |-> ($past(rnd_q) == ROUND_LAST))
		else $error("compression ended before the last round");
	assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> (cnt_q == 128'd0 && fill_q == 7'd0))
		else $error("length or fill left over after finalize");
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_LEN) |-> (fill_q >= LEN_START))
		else $error("length bytes outside the last sixteen bytes");
	assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> (state_q == S_IDLE && out_free))
		else $error("command taken while busy");

endmodule

/* hdl/sha512_hash_engine.sv */
// ----------------------------------------------------------------------------
// sha512_hash_engine
// SHA-512 engine driven by one command per transfer.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready): cmd, data_byte, partial_bits. Output
// channel (out_valid/out_ready): status, digest_word, word_index, last.
// Commands pass a two-entry queue into the back part, which handles one
// command at a time and answers through a single output register.
// Absorb appends one byte; every 128th byte also starts a compression
// (80 rounds plus the hash update) after its result is issued.
// Finalize appends the marker, zero bytes and 16 length bytes one per cycle,
// then compresses once or twice and issues eight words, one per cycle
// while the receiver takes them. Read issues eight words in that manner.
// Restart and error commands each give a single result. Reset loads the
// initial hash, clears length and done flag and empties the queue. A stalled
// receiver holds the output register; the back part waits and the queue
// fills, after which in_ready drops.
// ----------------------------------------------------------------------------
module sha512_hash_engine import sha512_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  cmd,
	input  logic [7:0]  data_byte,
	input  logic [2:0]  partial_bits,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        status,
	output logic [63:0] digest_word,
	output logic [2:0]  word_index,
	output logic        last
);

	logic  push;
	item_t push_item;
	logic  queue_full;
	logic  pop;
	logic  head_valid;
	item_t head_item;

	sha512_front u_front (
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.cmd          (cmd),
		.data_byte    (data_byte),
		.partial_bits (partial_bits),
		.push         (push),
		.push_item    (push_item),
		.queue_full   (queue_full)
	);

	sha512_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_item  (push_item),
		.full       (queue_full),
		.pop        (pop),
		.head_valid (head_valid),
		.head_item  (head_item)
	);

	sha512_core u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.head_valid  (head_valid),
		.head_item   (head_item),
		.pop         (pop),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.status      (status),
		.digest_word (digest_word),
		.word_index  (word_index),
		.last        (last)
	);

endmodule
